// ===== rtl/fpd_pkg.sv =====
// Package: opcodes, payload types and pipeline constants for the fixed-point unit
`default_nettype none
package fpd_pkg;

   typedef enum logic [3:0] {
      OP_D6FLOOR = 4'd0, OP_D6CEIL = 4'd1, OP_D6ROUND = 4'd2, OP_D6TO16 = 4'd3,
      OP_DIV = 4'd4, OP_MUL16 = 4'd5, OP_FLOOR16 = 4'd6, OP_CEIL16 = 4'd7,
      OP_ROUND16 = 4'd8, OP_TO8 = 4'd9, OP_SMALLSCALE = 4'd10, OP_CANCONV = 4'd11
   } op_type;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               fault;
   } rsp_type;

   // quotient bits for a 48-bit dividend magnitude
   localparam int QUO_W     = 48;
   localparam int DIV_W     = 32;
   localparam int DOT6_MAX  = 2097151;

   // Partial state handed from one divider cell to the next.
   typedef struct packed {
      logic              valid;
      logic [3:0]        op;
      logic [QUO_W-1:0]  dvd;   // remaining dividend bits, shifted up
      logic [DIV_W:0]    rem;   // partial remainder
      logic [DIV_W-1:0]  dvs;   // divisor magnitude
      logic              neg;   // quotient sign
      logic              dz;    // divide by zero
      logic signed [31:0] simple; // result of non-divide ops
      logic              sflt;  // fault of non-divide ops
   } cell_type;

endpackage
`default_nettype wire

// ===== rtl/fpd_cell.sv =====
// One restoring-divide cell: develops one quotient bit and hands the item on
`default_nettype none
module fpd_cell
   import fpd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire cell_type cell_in,
   output cell_type      cell_out
);
   cell_type cell_ff, cell_in_w;
   logic [DIV_W:0]   trial;
   logic [DIV_W+1:0] diff;

   always_comb begin
      cell_in_w = cell_in;
      trial = {cell_in.rem[DIV_W-1:0], cell_in.dvd[QUO_W-1]};
      diff  = {1'b0, trial} - {2'b00, cell_in.dvs};
      cell_in_w.dvd = {cell_in.dvd[QUO_W-2:0], ~diff[DIV_W+1]};
      cell_in_w.rem = diff[DIV_W+1] ? trial : diff[DIV_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.op     <= cell_in_w.op;
         cell_ff.dvd    <= cell_in_w.dvd;
         cell_ff.rem    <= cell_in_w.rem;
         cell_ff.dvs    <= cell_in_w.dvs;
         cell_ff.neg    <= cell_in_w.neg;
         cell_ff.dz     <= cell_in_w.dz;
         cell_ff.simple <= cell_in_w.simple;
         cell_ff.sflt   <= cell_in_w.sflt;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== rtl/fixed_point_dot6_dot16_alu_unit.sv =====
// Top level: fixed-point 26.6 / 16.16 arithmetic unit with a chain of divide cells
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | req_type  {op, operand_a, operand_b}
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_type  {result, fault}
//
// One request enters per cycle while the chain is not stalled; a request passes the
// input register, one cell per quotient bit of the 48-bit dividend and the output
// register; the sign fix-up in front of the output register is combinational.
// The whole chain advances together; it stalls only when the output holds a
// response and the consumer is not ready, and a bubble in the chain is kept.
// Synchronous active-high reset clears all valid bits; payloads are not reset.
// The non-divide ops are computed from the input register (the mul16 product is
// formed ahead of it) and ride alongside the divider cells.
`default_nettype none
module fixed_point_dot6_dot16_alu_unit
   import fpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   // stage 0 registers
   logic               s0_valid_ff;
   req_type            s0_req_ff;
   logic signed [63:0] prod_ff;
   logic               advance;
   cell_type           chain [0:QUO_W];
   cell_type           head;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   // advance when the output slot is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
      if (advance) begin
         s0_req_ff <= req_data;
         prod_ff   <= 64'(req_data.operand_a) * 64'(req_data.operand_b);
      end
   end

   // Compute the single-stage ops and prepare the divider operands.
   logic signed [32:0] a33, sum;
   logic signed [42:0] shl;
   logic [31:0]        amag, bmag;
   logic [6:0]         fac;
   logic [14:0]        scl;
   always_comb begin
      a33 = 33'(s0_req_ff.operand_a);
      sum = a33;
      shl = 43'(s0_req_ff.operand_a) <<< 10;
      head = '0;
      head.valid = s0_valid_ff;
      head.op    = s0_req_ff.op;
      amag = s0_req_ff.operand_a[31] ? 32'(-s0_req_ff.operand_a) : s0_req_ff.operand_a;
      bmag = s0_req_ff.operand_b[31] ? 32'(-s0_req_ff.operand_b) : s0_req_ff.operand_b;
      head.dvd = {amag, 16'd0};
      head.dvs = bmag;
      head.neg = s0_req_ff.operand_a[31] ^ s0_req_ff.operand_b[31];
      head.dz  = (s0_req_ff.operand_b == 32'sd0);
      fac = s0_req_ff.operand_a[31] ? 7'd0 :
            (s0_req_ff.operand_a > 32'sd64) ? 7'd64 : s0_req_ff.operand_a[6:0];
      scl = 15'(s0_req_ff.operand_b[7:0]) * 15'(fac);
      case (s0_req_ff.op)
         OP_D6FLOOR: head.simple = 32'(a33 >>> 6);
         OP_D6CEIL: begin
            sum = a33 + 33'sd63;
            head.simple = 32'(sum >>> 6);
         end
         OP_D6ROUND: begin
            sum = a33 + 33'sd32;
            head.simple = 32'(sum >>> 6);
         end
         OP_D6TO16: begin
            if (shl > 43'sd2147483647) begin
               head.simple = 32'h7FFF_FFFF; head.sflt = 1'b1;
            end else if (shl < -43'sd2147483648) begin
               head.simple = 32'h8000_0000; head.sflt = 1'b1;
            end else begin
               head.simple = 32'(shl);
            end
         end
         OP_MUL16: head.simple = 32'(prod_ff >>> 16);
         OP_FLOOR16: head.simple = 32'(a33 >>> 16);
         OP_CEIL16: begin
            sum = a33 + 33'sd65535;
            head.simple = 32'(sum >>> 16);
         end
         OP_ROUND16: begin
            sum = a33 + 33'sd32768;
            head.simple = 32'(sum >>> 16);
         end
         OP_TO8: begin
            sum = a33 + 33'sd128;
            head.simple = 32'(sum >>> 8);
         end
         OP_SMALLSCALE: head.simple = 32'(scl >> 6);
         OP_CANCONV: head.simple = (s0_req_ff.operand_a >= -32'sd2097151 &&
                                    s0_req_ff.operand_a <= 32'sd2097151) ? 32'd1 : 32'd0;
         default: head.simple = '0;
      endcase
   end

   assign chain[0] = head;

   // one cell per quotient bit
   for (genvar g = 0; g < QUO_W; g++) begin : g_cell
      fpd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_in (chain[g]),
         .cell_out(chain[g+1])
      );
   end

   // Apply sign and saturate the divide quotient; pick the response.
   logic [QUO_W-1:0] q;
   always_comb begin
      q = chain[QUO_W].dvd;
      rsp_in.fault  = chain[QUO_W].sflt;
      rsp_in.result = chain[QUO_W].simple;
      if (chain[QUO_W].op == OP_DIV) begin
         if (chain[QUO_W].dz) begin
            rsp_in.result = '0; rsp_in.fault = 1'b1;
         end else if (!chain[QUO_W].neg) begin
            if (q > 48'h0000_7FFF_FFFF) begin
               rsp_in.result = 32'h7FFF_FFFF; rsp_in.fault = 1'b1;
            end else begin
               rsp_in.result = q[31:0]; rsp_in.fault = 1'b0;
            end
         end else begin
            if (q > 48'h0000_8000_0000) begin
               rsp_in.result = 32'h8000_0000; rsp_in.fault = 1'b1;
            end else begin
               rsp_in.result = 32'(-q[31:0]); rsp_in.fault = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[QUO_W].valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
